FILE: hw/rtl/hte_pkg.sv
// Shared types, codes and character mapping for the Huffman train/encode/decode core.
// Used by hte_ctrl, hte_dp and the top level.
`default_nettype none

package hte_pkg;

	// operation field codes
	localparam logic [1:0] OP_TRAIN  = 2'd0;
	localparam logic [1:0] OP_ENCODE = 2'd1;
	localparam logic [1:0] OP_DECODE = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_INVALID  = 2'd1;
	localparam logic [1:0] ST_NO_TABLE = 2'd2;

	localparam logic [7:0] PERIOD_IDX = 8'd2;
	localparam logic [7:0] NO_SYMBOL  = 8'hFF;
	localparam logic [3:0] MAX_RESULTS = 4'd8;

	// datapath commands
	typedef logic [4:0] cmd_t;
	localparam cmd_t C_NOP    = 5'd0;
	localparam cmd_t C_LOAD   = 5'd1;
	localparam cmd_t C_WRD    = 5'd2;
	localparam cmd_t C_WWR    = 5'd3;
	localparam cmd_t C_BSTART = 5'd4;
	localparam cmd_t C_BIRD   = 5'd5;
	localparam cmd_t C_BIWR   = 5'd6;
	localparam cmd_t C_SCST   = 5'd7;
	localparam cmd_t C_SCSTEP = 5'd8;
	localparam cmd_t C_MERGE  = 5'd9;
	localparam cmd_t C_CROOT  = 5'd10;
	localparam cmd_t C_CRDN   = 5'd11;
	localparam cmd_t C_CWL    = 5'd12;
	localparam cmd_t C_CWR    = 5'd13;
	localparam cmd_t C_BDONE  = 5'd14;
	localparam cmd_t C_CRD    = 5'd15;
	localparam cmd_t C_ELOAD  = 5'd16;
	localparam cmd_t C_EBIT   = 5'd17;
	localparam cmd_t C_EFL    = 5'd18;
	localparam cmd_t C_DINIT  = 5'd19;
	localparam cmd_t C_DRD    = 5'd20;
	localparam cmd_t C_DSTEP  = 5'd21;
	localparam cmd_t C_ROK    = 5'd22;
	localparam cmd_t C_RINV   = 5'd23;
	localparam cmd_t C_RNB    = 5'd24;
	localparam cmd_t C_FIN    = 5'd25;

	// datapath status toward the controller
	typedef struct packed {
		logic [1:0] op;
		logic       sym_ok;
		logic       built;
		logic       is_period;
		logic       idx_last;
		logic       sc_done;
		logic       merge_all;
		logic       n_last;
		logic       w_zero;
		logic       d_stop;
		logic       can_push;
	} stat_t;

	// ASCII to symbol index, NO_SYMBOL when outside the alphabet
	function automatic logic [7:0] sym_index(input logic [7:0] c);
		logic [7:0] i;
		i = NO_SYMBOL;
		if (c == 8'h20) i = 8'd0;
		else if (c == 8'h2C) i = 8'd1;
		else if (c == 8'h2E) i = 8'd2;
		else if (c >= 8'h41 && c <= 8'h5A) i = c - 8'h41 + 8'd3;
		else if (c >= 8'h61 && c <= 8'h7A) i = c - 8'h61 + 8'd29;
		return i;
	endfunction

	// symbol index to ASCII, zero past the alphabet
	function automatic logic [7:0] sym_char(input logic [7:0] i);
		logic [7:0] c;
		c = 8'd0;
		if (i == 8'd0) c = 8'h20;
		else if (i == 8'd1) c = 8'h2C;
		else if (i == 8'd2) c = 8'h2E;
		else if (i <= 8'd28) c = i - 8'd3 + 8'h41;
		else if (i <= 8'd54) c = i - 8'd29 + 8'h61;
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/hte_dp.sv
// Datapath: weight, node, child and code memories, tree scan, bit packer,
// tree walker and result staging. Depends on hte_pkg; driven by hte_ctrl.
`default_nettype none

module hte_dp import hte_pkg::*; #(
	parameter int N = 55,
	parameter int W = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cmd_t       cmd,
	input  wire logic [1:0] op_in,
	input  wire logic [7:0] ch_in,
	input  wire logic       out_ready,
	output stat_t           st,
	output logic            out_valid,
	output logic [1:0]      out_status,
	output logic [7:0]      out_value,
	output logic            out_last
);
	localparam int SB    = $clog2(N);
	localparam int NODES = 2 * N - 1;
	localparam int ROOT  = 2 * N - 2;
	localparam int NB    = $clog2(NODES);
	localparam int NWW   = W + SB;
	localparam int CW    = N - 1;
	localparam int LW    = $clog2(N);

	// input word
	logic [1:0]    op_q;
	logic [7:0]    ch_q;
	logic [SB-1:0] s_q;
	logic          sym_ok_q, built_q;
	logic [7:0]    sidx;

	// memories
	logic [W-1:0]         sw_mem [N];
	logic [N-1:0]         swv_q;
	logic [W-1:0]         sw_rd_q;
	logic                 swv_rd_q;
	logic [NWW+SB-1:0]    nd_mem [NODES];
	logic [NWW+SB-1:0]    nd_rd_q;
	logic [2*NB-1:0]      ch_mem [N];
	logic [2*NB-1:0]      ch_rd_q;
	logic [CW+LW-1:0]     cd_mem [NODES];
	logic [CW+LW-1:0]     cd_rd_q;

	// build control
	logic [NODES-1:0] alive_q;
	logic [NB-1:0]    idx_q, next_q, n_q;
	logic             v_s1, al_s1;
	logic [NB-1:0]    i_s1;
	logic             have1_q, have2_q;
	logic [NWW-1:0]   b1w_q, b2w_q;
	logic [SB-1:0]    b1k_q, b2k_q;
	logic [NB-1:0]    b1i_q, b2i_q;

	// encode / decode
	logic [CW-1:0] code_q;
	logic [LW-1:0] w_q;
	logic [7:0]    acc_q;
	logic [3:0]    cnt_q;
	logic [NB-1:0] pos_q;
	logic [2:0]    bit_q;

	// result staging
	logic       pend_v_q;
	logic [1:0] pend_st_q;
	logic [7:0] pend_val_q;
	logic [3:0] k_q;

	function automatic logic less(input logic [NWW-1:0] wa, input logic [SB-1:0] ka,
			input logic [NWW-1:0] wb, input logic [SB-1:0] kb);
		return (wa < wb) || (wa == wb && ka < kb);
	endfunction

	// derived values
	logic [W-1:0]    cur_w, inc_w;
	logic [NWW-1:0]  cand_w;
	logic [SB-1:0]   cand_k;
	logic [CW-1:0]   cd_code;
	logic [LW-1:0]   cd_len;
	logic [NB-1:0]   ch_l, ch_r, child;
	logic [SB-1:0]   n_off, pos_off;
	logic            leaf, leaf_period;
	logic [7:0]      leaf_char, nacc;
	logic [3:0]      ncnt;
	logic            res_en;
	logic [1:0]      res_st;
	logic [7:0]      res_val;
	logic            out_load;

	assign sidx    = sym_index(ch_in);
	assign cur_w   = swv_rd_q ? sw_rd_q : '0;
	assign inc_w   = (cur_w == {W{1'b1}}) ? cur_w : cur_w + W'(1);
	assign cand_w  = nd_rd_q[NWW+SB-1:SB];
	assign cand_k  = nd_rd_q[SB-1:0];
	assign cd_code = cd_rd_q[CW+LW-1:LW];
	assign cd_len  = cd_rd_q[LW-1:0];
	assign ch_l    = ch_rd_q[2*NB-1:NB];
	assign ch_r    = ch_rd_q[NB-1:0];
	assign child   = ch_q[bit_q] ? ch_r : ch_l;
	assign leaf    = child < NB'(N);
	assign leaf_period = leaf && (8'(child) == PERIOD_IDX);
	assign leaf_char   = sym_char(8'(child));
	assign n_off   = SB'(n_q - NB'(N));
	assign pos_off = SB'(pos_q - NB'(N));
	assign nacc    = {acc_q[6:0], code_q[CW-1]};
	assign ncnt    = cnt_q + 4'd1;

	// status toward controller
	always_comb begin
		st.op        = op_q;
		st.sym_ok    = sym_ok_q;
		st.built     = built_q;
		st.is_period = (8'(s_q) == PERIOD_IDX);
		st.idx_last  = (idx_q == NB'(N - 1));
		st.sc_done   = (idx_q == next_q) && !v_s1;
		st.merge_all = (next_q == NB'(NODES));
		st.n_last    = (n_q == NB'(N));
		st.w_zero    = (w_q == '0);
		st.d_stop    = leaf_period || (bit_q == 3'd0);
		st.can_push  = !pend_v_q || !out_valid || out_ready;
	end

	// result produced by the current command
	always_comb begin
		res_en  = 1'b0;
		res_st  = ST_OK;
		res_val = 8'd0;
		case (cmd)
			C_ROK: res_en = 1'b1;
			C_RINV: begin
				res_en = 1'b1;
				res_st = ST_INVALID;
			end
			C_RNB: begin
				res_en = 1'b1;
				res_st = ST_NO_TABLE;
			end
			C_EBIT: begin
				res_en  = (ncnt == 4'd8);
				res_val = nacc;
			end
			C_EFL: begin
				res_en  = st.is_period && (cnt_q != 4'd0);
				res_val = 8'(acc_q << (4'd8 - cnt_q));
			end
			C_DSTEP: begin
				res_en  = leaf;
				res_val = leaf_char;
				res_st  = (leaf_char != 8'd0) ? ST_OK : ST_INVALID;
			end
			default: ;
		endcase
	end

	assign out_load = pend_v_q && ((res_en && k_q < MAX_RESULTS) || cmd == C_FIN);

	// output register and staging of the most recent result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			pend_v_q  <= 1'b0;
			k_q       <= 4'd0;
		end else begin
			if (out_load) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			if (cmd == C_FIN) begin
				pend_v_q <= 1'b0;
				k_q      <= 4'd0;
			end else if (res_en && k_q < MAX_RESULTS) begin
				pend_v_q <= 1'b1;
				k_q      <= k_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status <= pend_st_q;
			out_value  <= pend_val_q;
			out_last   <= (cmd == C_FIN);
		end
		if (res_en && k_q < MAX_RESULTS && cmd != C_FIN) begin
			pend_st_q  <= res_st;
			pend_val_q <= res_val;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swv_q   <= '0;
			built_q <= 1'b0;
			acc_q   <= 8'd0;
			cnt_q   <= 4'd0;
			pos_q   <= NB'(ROOT);
			alive_q <= '0;
			v_s1    <= 1'b0;
			have1_q <= 1'b0;
			have2_q <= 1'b0;
		end else begin
			case (cmd)
				C_WWR: swv_q[s_q] <= 1'b1;
				C_BSTART: alive_q <= '0;
				C_BIWR: alive_q[idx_q] <= 1'b1;
				C_SCST: begin
					v_s1    <= 1'b0;
					have1_q <= 1'b0;
					have2_q <= 1'b0;
				end
				C_SCSTEP: begin
					v_s1 <= (idx_q < next_q);
					if (v_s1 && al_s1) begin
						if (!have1_q || less(cand_w, cand_k, b1w_q, b1k_q)) begin
							have1_q <= 1'b1;
							have2_q <= have1_q;
						end else if (!have2_q || less(cand_w, cand_k, b2w_q, b2k_q)) begin
							have2_q <= 1'b1;
						end
					end
				end
				// retire both children, the new node goes live
				C_MERGE: alive_q <= (alive_q & ~(NODES'(1) << b1i_q) & ~(NODES'(1) << b2i_q))
					| (NODES'(1) << next_q);
				C_BDONE: begin
					built_q <= 1'b1;
					acc_q   <= 8'd0;
					cnt_q   <= 4'd0;
					pos_q   <= NB'(ROOT);
				end
				C_EBIT: begin
					if (ncnt == 4'd8) begin
						acc_q <= 8'd0;
						cnt_q <= 4'd0;
					end else begin
						acc_q <= nacc;
						cnt_q <= ncnt;
					end
				end
				C_EFL: begin
					if (st.is_period) begin
						acc_q <= 8'd0;
						cnt_q <= 4'd0;
					end
				end
				C_DINIT: begin
					if (pos_q < NB'(N) || pos_q > NB'(ROOT)) pos_q <= NB'(ROOT);
				end
				C_DSTEP: pos_q <= leaf ? NB'(ROOT) : child;
				default: ;
			endcase
		end
	end

	// payload registers and memories
	always_ff @(posedge clk) begin
		case (cmd)
			C_LOAD: begin
				op_q     <= op_in;
				ch_q     <= ch_in;
				s_q      <= sidx[SB-1:0];
				sym_ok_q <= (sidx != NO_SYMBOL) && (sidx < 8'(N));
			end
			C_WRD: begin
				sw_rd_q  <= sw_mem[s_q];
				swv_rd_q <= swv_q[s_q];
			end
			C_WWR: sw_mem[s_q] <= inc_w;
			C_BSTART: begin
				idx_q  <= '0;
				next_q <= NB'(N);
			end
			C_BIRD: begin
				sw_rd_q  <= sw_mem[idx_q[SB-1:0]];
				swv_rd_q <= swv_q[idx_q[SB-1:0]];
			end
			C_BIWR: begin
				nd_mem[idx_q] <= {NWW'(cur_w), idx_q[SB-1:0]};
				idx_q         <= idx_q + NB'(1);
			end
			C_SCST: idx_q <= '0;
			C_SCSTEP: begin
				if (idx_q < next_q) begin
					nd_rd_q <= nd_mem[idx_q];
					al_s1   <= alive_q[idx_q];
					i_s1    <= idx_q;
					idx_q   <= idx_q + NB'(1);
				end
				// keep the two smallest live nodes
				if (v_s1 && al_s1) begin
					if (!have1_q || less(cand_w, cand_k, b1w_q, b1k_q)) begin
						b2w_q <= b1w_q;
						b2k_q <= b1k_q;
						b2i_q <= b1i_q;
						b1w_q <= cand_w;
						b1k_q <= cand_k;
						b1i_q <= i_s1;
					end else if (!have2_q || less(cand_w, cand_k, b2w_q, b2k_q)) begin
						b2w_q <= cand_w;
						b2k_q <= cand_k;
						b2i_q <= i_s1;
					end
				end
			end
			C_MERGE: begin
				nd_mem[next_q] <= {NWW'(b1w_q + b2w_q), b1k_q};
				ch_mem[SB'(next_q - NB'(N))] <= {b1i_q, b2i_q};
				next_q <= next_q + NB'(1);
			end
			C_CROOT: begin
				cd_mem[NB'(ROOT)] <= '0;
				n_q <= NB'(ROOT);
			end
			C_CRDN: begin
				cd_rd_q <= cd_mem[n_q];
				ch_rd_q <= ch_mem[n_off];
			end
			C_CWL: cd_mem[ch_l] <= {CW'(cd_code << 1), LW'(cd_len + LW'(1))};
			C_CWR: begin
				cd_mem[ch_r] <= {CW'(cd_code << 1) | CW'(1), LW'(cd_len + LW'(1))};
				n_q <= n_q - NB'(1);
			end
			C_CRD: cd_rd_q <= cd_mem[NB'(s_q)];
			C_ELOAD: begin
				code_q <= CW'(cd_code << (LW'(CW) - cd_len));
				w_q    <= cd_len;
			end
			C_EBIT: begin
				code_q <= CW'(code_q << 1);
				w_q    <= w_q - LW'(1);
			end
			C_DINIT: bit_q <= 3'd7;
			C_DRD: ch_rd_q <= ch_mem[pos_off];
			C_DSTEP: bit_q <= bit_q - 3'd1;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

FILE: hw/rtl/hte_ctrl.sv
// Controller state machine: sequences train, tree build, encode and decode
// through datapath commands. Depends on hte_pkg.
`default_nettype none

module hte_ctrl import hte_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire stat_t st,
	output cmd_t       cmd
);
	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_DISP  = 5'd1;
	localparam logic [4:0] S_TRW   = 5'd2;
	localparam logic [4:0] S_TOK   = 5'd3;
	localparam logic [4:0] S_BINIT = 5'd4;
	localparam logic [4:0] S_BIRD  = 5'd5;
	localparam logic [4:0] S_BIWR  = 5'd6;
	localparam logic [4:0] S_SCAN0 = 5'd7;
	localparam logic [4:0] S_SCAN  = 5'd8;
	localparam logic [4:0] S_MCHK  = 5'd9;
	localparam logic [4:0] S_CINIT = 5'd10;
	localparam logic [4:0] S_CRD   = 5'd11;
	localparam logic [4:0] S_CWL   = 5'd12;
	localparam logic [4:0] S_CWR   = 5'd13;
	localparam logic [4:0] S_BDONE = 5'd14;
	localparam logic [4:0] S_ECL   = 5'd15;
	localparam logic [4:0] S_EBIT  = 5'd16;
	localparam logic [4:0] S_EFL   = 5'd17;
	localparam logic [4:0] S_DRD   = 5'd18;
	localparam logic [4:0] S_DST   = 5'd19;
	localparam logic [4:0] S_FIN   = 5'd20;

	logic [4:0] state_q, nxt;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		nxt = state_q;
		cmd = C_NOP;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd = C_LOAD;
					nxt = S_DISP;
				end
			end
			// dispatch on operation
			S_DISP: begin
				if ((st.op == OP_TRAIN || st.op == OP_ENCODE) && !st.sym_ok) begin
					if (st.can_push) begin
						cmd = C_RINV;
						nxt = S_FIN;
					end
				end else if (st.op == OP_TRAIN) begin
					cmd = C_WRD;
					nxt = S_TRW;
				end else if ((st.op == OP_ENCODE || st.op == OP_DECODE) && !st.built) begin
					if (st.can_push) begin
						cmd = C_RNB;
						nxt = S_FIN;
					end
				end else if (st.op == OP_ENCODE) begin
					cmd = C_CRD;
					nxt = S_ECL;
				end else if (st.op == OP_DECODE) begin
					cmd = C_DINIT;
					nxt = S_DRD;
				end else begin
					nxt = S_FIN;
				end
			end
			// training
			S_TRW: begin
				cmd = C_WWR;
				nxt = st.is_period ? S_BINIT : S_TOK;
			end
			S_TOK: begin
				if (st.can_push) begin
					cmd = C_ROK;
					nxt = S_FIN;
				end
			end
			// tree build: load leaves
			S_BINIT: begin
				cmd = C_BSTART;
				nxt = S_BIRD;
			end
			S_BIRD: begin
				cmd = C_BIRD;
				nxt = S_BIWR;
			end
			S_BIWR: begin
				cmd = C_BIWR;
				nxt = st.idx_last ? S_SCAN0 : S_BIRD;
			end
			// merge two smallest live nodes per scan
			S_SCAN0: begin
				cmd = C_SCST;
				nxt = S_SCAN;
			end
			S_SCAN: begin
				if (st.sc_done) begin
					cmd = C_MERGE;
					nxt = S_MCHK;
				end else begin
					cmd = C_SCSTEP;
				end
			end
			S_MCHK: nxt = st.merge_all ? S_CINIT : S_SCAN0;
			// code assignment, root downward
			S_CINIT: begin
				cmd = C_CROOT;
				nxt = S_CRD;
			end
			S_CRD: begin
				cmd = C_CRDN;
				nxt = S_CWL;
			end
			S_CWL: begin
				cmd = C_CWL;
				nxt = S_CWR;
			end
			S_CWR: begin
				cmd = C_CWR;
				nxt = st.n_last ? S_BDONE : S_CRD;
			end
			S_BDONE: begin
				cmd = C_BDONE;
				nxt = S_TOK;
			end
			// encode
			S_ECL: begin
				cmd = C_ELOAD;
				nxt = S_EBIT;
			end
			S_EBIT: begin
				if (st.w_zero) nxt = S_EFL;
				else if (st.can_push) cmd = C_EBIT;
			end
			S_EFL: begin
				if (st.can_push) begin
					cmd = C_EFL;
					nxt = S_FIN;
				end
			end
			// decode
			S_DRD: begin
				cmd = C_DRD;
				nxt = S_DST;
			end
			S_DST: begin
				if (st.can_push) begin
					cmd = C_DSTEP;
					nxt = st.d_stop ? S_FIN : S_DRD;
				end
			end
			S_FIN: begin
				if (st.can_push) begin
					cmd = C_FIN;
					nxt = S_IDLE;
				end
			end
			default: nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= nxt;
	end

endmodule

`default_nettype wire

FILE: hw/rtl/huffman_train_encode_decode_core.sv
// Huffman train/encode/decode core. One word in flight at a time.
// Train: weight update. Trained period: also builds the tree over the node memory.
// Encode shifts out the symbol's code; decode walks the tree bit by bit.
// Output register decouples the result side. Reset: weights zero, table unbuilt.
`default_nettype none

module huffman_train_encode_decode_core import hte_pkg::*; #(
	parameter int NUM_SYMBOLS = 55,
	parameter int WEIGHT_BITS = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] operation,
	input  wire logic [7:0] char_or_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [1:0]      status,
	output logic [7:0]      value,
	output logic            last
);
	cmd_t  cmd;
	stat_t st;

	hte_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	hte_dp #(
		.N (NUM_SYMBOLS),
		.W (WEIGHT_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.op_in      (operation),
		.ch_in      (char_or_byte),
		.out_ready  (out_ready),
		.st         (st),
		.out_valid  (out_valid),
		.out_status (status),
		.out_value  (value),
		.out_last   (last)
	);

endmodule

`default_nettype wire
